>>> design/pcst_pkg.sv
// Package for the peer connection slot table.
// Holds item types, command and status codes and default sizes.
// No dependencies.
`default_nettype none

package pcst_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int NODE_W         = 8;
    localparam int SLOT_W         = 3;
    localparam int INDEX_W        = 4;

    localparam logic [NODE_W-1:0] NODE_FREE  = 8'h00;
    localparam logic [NODE_W-1:0] NODE_BCAST = 8'hFF;

    localparam logic [1:0] CMD_OPEN    = 2'd0;
    localparam logic [1:0] CMD_RECEIVE = 2'd1;
    localparam logic [1:0] CMD_DELETE  = 2'd2;
    localparam logic [1:0] CMD_READ    = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_NODE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_BAD_SLOT = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic [NODE_W-1:0]  node_id;
        logic [INDEX_W-1:0] slot_index;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [NODE_W-1:0]  peer_node;
        logic [1:0]         status;
    } rsp_t;

endpackage

`default_nettype wire

>>> design/pcst_stream_if.sv
// Valid/ready channel carrying one item per handshake.
// Payload type is a parameter; used with pcst_pkg item types.
`default_nettype none

interface pcst_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

>>> design/peer_connection_slot_table_core.sv
// Peer connection slot table: a table of SLOT_COUNT node ids (0 = free slot)
// served by a sequencer that compares one slot per cycle against the item's node.
// Open and receive scan the slots in order, then pass through a claim step and a
// result step; a match ends the scan early and skips the claim, and an open with a
// bad node goes straight to the result step. Delete and read go straight to the
// result step. The result is held on rsp until taken; req is not ready meanwhile.
// Depends on pcst_pkg and pcst_stream_if.
`default_nettype none

module peer_connection_slot_table_core #(
    parameter int SLOT_COUNT = pcst_pkg::SLOT_COUNT_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    pcst_stream_if.sink       req,
    pcst_stream_if.source     rsp
);

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(SLOT_COUNT - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_CLAIM = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t                          st_reg, st_next;
    logic [pcst_pkg::NODE_W-1:0]     tbl_reg [SLOT_COUNT];
    logic [AW-1:0]                   cnt_reg, cnt_next;
    logic [AW-1:0]                   free_reg, free_next;
    logic                            have_free_reg, have_free_next;
    logic [1:0]                      cmd_reg, cmd_next;
    logic [pcst_pkg::NODE_W-1:0]     node_reg, node_next;
    pcst_pkg::rsp_t                  res_reg, res_next;

    logic [AW-1:0]                   rd_idx;
    logic [pcst_pkg::NODE_W-1:0]     rd_data;
    logic                            wr_en;
    logic [AW-1:0]                   wr_idx;
    logic [pcst_pkg::NODE_W-1:0]     wr_data;
    logic                            bad_idx;
    logic [AW-1:0]                   req_idx;

    assign req_idx = req.payload.slot_index[AW-1:0];
    assign bad_idx = 32'(req.payload.slot_index) >= 32'(SLOT_COUNT);
    assign rd_idx  = (st_reg == S_IDLE) ? req_idx : cnt_reg;
    assign rd_data = tbl_reg[rd_idx];

    assign req.ready   = (st_reg == S_IDLE);
    assign rsp.valid   = (st_reg == S_OUT);
    assign rsp.payload = res_reg;

    always_comb
    begin
        st_next        = st_reg;
        cnt_next       = cnt_reg;
        free_next      = free_reg;
        have_free_next = have_free_reg;
        cmd_next       = cmd_reg;
        node_next      = node_reg;
        res_next       = res_reg;
        wr_en          = 1'b0;
        wr_idx         = free_reg;
        wr_data        = node_reg;

        unique case (st_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next       = req.payload.command;
                    node_next      = req.payload.node_id;
                    cnt_next       = '0;
                    have_free_next = 1'b0;
                    res_next       = '{slot: '0, peer_node: '0, status: pcst_pkg::ST_OK};
                    unique case (req.payload.command)
                        pcst_pkg::CMD_OPEN:
                        begin
                            if (req.payload.node_id == pcst_pkg::NODE_FREE ||
                                req.payload.node_id == pcst_pkg::NODE_BCAST)
                            begin
                                res_next.status = pcst_pkg::ST_BAD_NODE;
                                st_next         = S_OUT;
                            end
                            else
                            begin
                                st_next = S_SCAN;
                            end
                        end
                        pcst_pkg::CMD_RECEIVE:
                        begin
                            st_next = S_SCAN;
                        end
                        pcst_pkg::CMD_DELETE:
                        begin
                            if (bad_idx)
                            begin
                                res_next.status = pcst_pkg::ST_BAD_SLOT;
                            end
                            else
                            begin
                                wr_en         = 1'b1;
                                wr_idx        = req_idx;
                                wr_data       = pcst_pkg::NODE_FREE;
                                res_next.slot = pcst_pkg::SLOT_W'(req_idx);
                            end
                            st_next = S_OUT;
                        end
                        default:
                        begin
                            if (bad_idx)
                            begin
                                res_next.status = pcst_pkg::ST_BAD_SLOT;
                            end
                            else
                            begin
                                res_next.slot      = pcst_pkg::SLOT_W'(req_idx);
                                res_next.peer_node = rd_data;
                            end
                            st_next = S_OUT;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (rd_data == node_reg)
                begin
                    res_next.slot = pcst_pkg::SLOT_W'(cnt_reg);
                    st_next       = S_OUT;
                end
                else
                begin
                    if (rd_data == pcst_pkg::NODE_FREE &&
                        (cmd_reg == pcst_pkg::CMD_OPEN || !have_free_reg))
                    begin
                        have_free_next = 1'b1;
                        free_next      = cnt_reg;
                    end
                    if (cnt_reg == LAST_IDX)
                    begin
                        st_next = S_CLAIM;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            S_CLAIM:
            begin
                if (have_free_reg)
                begin
                    wr_en         = 1'b1;
                    res_next.slot = pcst_pkg::SLOT_W'(free_reg);
                end
                else
                begin
                    res_next.status = pcst_pkg::ST_FULL;
                end
                st_next = S_OUT;
            end
            S_OUT:
            begin
                if (rsp.ready)
                begin
                    st_next = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            cnt_reg       <= '0;
            have_free_reg <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                tbl_reg[i] <= pcst_pkg::NODE_FREE;
            end
        end
        else
        begin
            st_reg        <= st_next;
            cnt_reg       <= cnt_next;
            have_free_reg <= have_free_next;
            if (wr_en)
            begin
                tbl_reg[wr_idx] <= wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        free_reg <= free_next;
        cmd_reg  <= cmd_next;
        node_reg <= node_next;
        res_reg  <= res_next;
    end

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !req.ready)
        else $error("request ready while a result is pending");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.payload.status != pcst_pkg::ST_OK) |->
            (rsp.payload.slot == '0 && rsp.payload.peer_node == '0))
        else $error("error result carries nonzero slot or node");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (st_reg != S_IDLE))
        else $error("accepted item did not start work");

    a_claim_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_CLAIM) |=> (st_reg == S_OUT))
        else $error("claim step did not produce a result");

    a_node_only_read: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && cmd_reg != pcst_pkg::CMD_READ) |-> (rsp.payload.peer_node == '0))
        else $error("peer node reported for a command other than read");

endmodule

`default_nettype wire

>>> sim/tb_peer_connection_slot_table_core.sv
`timescale 1ns / 100ps
// Testbench for peer_connection_slot_table_core: a directed table, then random commands
// on a small node pool. Results are checked against a local slot-table model.
// Depends on pcst_pkg, pcst_stream_if and the core.

module tb_peer_connection_slot_table_core;

    localparam int SLOTS        = pcst_pkg::SLOT_COUNT_DEF;
    localparam int RANDOM_ITEMS = 750;
    localparam int QUIET_ITEMS  = 100;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PLAN_ROWS    = 25;

    typedef struct {
        pcst_pkg::req_t item;
        bit             typed;
        pcst_pkg::rsp_t want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   quiet = 1'b0;
    int   errors = 0;
    int   cycles = 0;

    logic [pcst_pkg::NODE_W-1:0] peer_slots [SLOTS];
    pcst_pkg::rsp_t              slot_replies [$];

    pcst_stream_if #(.payload_t(pcst_pkg::req_t)) req ();
    pcst_stream_if #(.payload_t(pcst_pkg::rsp_t)) rsp ();

    peer_connection_slot_table_core #(.SLOT_COUNT(SLOTS)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    plan_row_t opening_plan [PLAN_ROWS] = '{
        '{'{pcst_pkg::CMD_READ,    8'h00, 4'd0},  1'b1, '{3'd0, 8'h00, pcst_pkg::ST_OK}},
        '{'{pcst_pkg::CMD_READ,    8'hFF, 4'd15}, 1'b1, '{3'd0, 8'h00, pcst_pkg::ST_BAD_SLOT}},
        '{'{pcst_pkg::CMD_DELETE,  8'h00, 4'd8},  1'b1, '{3'd0, 8'h00, pcst_pkg::ST_BAD_SLOT}},
        '{'{pcst_pkg::CMD_OPEN,    8'h00, 4'd0},  1'b1, '{3'd0, 8'h00, pcst_pkg::ST_BAD_NODE}},
        '{'{pcst_pkg::CMD_OPEN,    8'hFF, 4'd15}, 1'b1, '{3'd0, 8'h00, pcst_pkg::ST_BAD_NODE}},
        '{'{pcst_pkg::CMD_OPEN,    8'h01, 4'd0},  1'b1, '{3'd7, 8'h00, pcst_pkg::ST_OK}},
        '{'{pcst_pkg::CMD_OPEN,    8'h01, 4'd5},  1'b0, '0},
        '{'{pcst_pkg::CMD_RECEIVE, 8'hFF, 4'd0},  1'b1, '{3'd0, 8'h00, pcst_pkg::ST_OK}},
        '{'{pcst_pkg::CMD_RECEIVE, 8'h00, 4'd10}, 1'b0, '0},
        '{'{pcst_pkg::CMD_RECEIVE, 8'hFE, 4'd0},  1'b0, '0},
        '{'{pcst_pkg::CMD_RECEIVE, 8'h00, 4'd3},  1'b0, '0},
        '{'{pcst_pkg::CMD_OPEN,    8'h80, 4'd0},  1'b0, '0},
        '{'{pcst_pkg::CMD_OPEN,    8'h55, 4'd0},  1'b0, '0},
        '{'{pcst_pkg::CMD_OPEN,    8'hAA, 4'd0},  1'b0, '0},
        '{'{pcst_pkg::CMD_OPEN,    8'h7F, 4'd0},  1'b0, '0},
        '{'{pcst_pkg::CMD_RECEIVE, 8'h33, 4'd0},  1'b0, '0},
        '{'{pcst_pkg::CMD_OPEN,    8'h44, 4'd0},  1'b1, '{3'd0, 8'h00, pcst_pkg::ST_FULL}},
        '{'{pcst_pkg::CMD_RECEIVE, 8'h44, 4'd0},  1'b1, '{3'd0, 8'h00, pcst_pkg::ST_FULL}},
        '{'{pcst_pkg::CMD_RECEIVE, 8'h00, 4'd0},  1'b1, '{3'd0, 8'h00, pcst_pkg::ST_FULL}},
        '{'{pcst_pkg::CMD_READ,    8'h00, 4'd7},  1'b0, '0},
        '{'{pcst_pkg::CMD_READ,    8'h00, 4'd0},  1'b0, '0},
        '{'{pcst_pkg::CMD_DELETE,  8'h00, 4'd7},  1'b0, '0},
        '{'{pcst_pkg::CMD_READ,    8'h00, 4'd7},  1'b0, '0},
        '{'{pcst_pkg::CMD_DELETE,  8'h00, 4'd15}, 1'b1, '{3'd0, 8'h00, pcst_pkg::ST_BAD_SLOT}},
        '{'{pcst_pkg::CMD_OPEN,    8'hFE, 4'd0},  1'b0, '0}
    };

    logic [pcst_pkg::NODE_W-1:0] node_pool [12] = '{
        8'h00, 8'h01, 8'h02, 8'h03, 8'h10, 8'h42,
        8'h5A, 8'h7F, 8'h80, 8'hA5, 8'hFE, 8'hFF
    };

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic pcst_pkg::rsp_t resolve_slot(input pcst_pkg::req_t item);
        pcst_pkg::rsp_t res;
        int             hit;
        int             free_lo;
        int             free_hi;
        int             pick;
        res = '{slot: '0, peer_node: pcst_pkg::NODE_FREE, status: pcst_pkg::ST_OK};
        if (item.command == pcst_pkg::CMD_OPEN || item.command == pcst_pkg::CMD_RECEIVE)
        begin
            hit = -1;
            free_lo = -1;
            free_hi = -1;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (hit < 0 && peer_slots[i] == item.node_id)
                    hit = i;
                if (peer_slots[i] == pcst_pkg::NODE_FREE)
                begin
                    if (free_lo < 0)
                        free_lo = i;
                    free_hi = i;
                end
            end
            pick = (item.command == pcst_pkg::CMD_OPEN) ? free_hi : free_lo;
            if (item.command == pcst_pkg::CMD_OPEN &&
                (item.node_id == pcst_pkg::NODE_FREE || item.node_id == pcst_pkg::NODE_BCAST))
                res.status = pcst_pkg::ST_BAD_NODE;
            else if (hit >= 0)
                res.slot = pcst_pkg::SLOT_W'(hit);
            else if (pick < 0)
                res.status = pcst_pkg::ST_FULL;
            else
            begin
                peer_slots[pick] = item.node_id;
                res.slot = pcst_pkg::SLOT_W'(pick);
            end
        end
        else if (item.slot_index >= SLOTS)
            res.status = pcst_pkg::ST_BAD_SLOT;
        else
        begin
            res.slot = pcst_pkg::SLOT_W'(item.slot_index);
            if (item.command == pcst_pkg::CMD_DELETE)
                peer_slots[item.slot_index] = pcst_pkg::NODE_FREE;
            else
                res.peer_node = peer_slots[item.slot_index];
        end
        return res;
    endfunction

    task automatic issue(input pcst_pkg::req_t item, input bit typed,
                         input pcst_pkg::rsp_t want);
        pcst_pkg::rsp_t predicted;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        req.valid   <= 1'b1;
        req.payload <= item;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predicted = resolve_slot(item);
        slot_replies.push_back(typed ? want : predicted);
    endtask

    task automatic drain_replies();
        req.valid <= 1'b0;
        while (slot_replies.size() != 0)
            @(posedge clk);
    endtask

    function automatic pcst_pkg::req_t random_item();
        pcst_pkg::req_t item;
        int             pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            item.command = pcst_pkg::CMD_OPEN;
        else if (pick < 65)
            item.command = pcst_pkg::CMD_RECEIVE;
        else if (pick < 85)
            item.command = pcst_pkg::CMD_DELETE;
        else
            item.command = pcst_pkg::CMD_READ;
        if ($urandom_range(0, 4) == 0)
            item.node_id = pcst_pkg::NODE_W'($urandom_range(0, 255));
        else
            item.node_id = node_pool[$urandom_range(0, 11)];
        if ($urandom_range(0, 6) == 0)
            item.slot_index = pcst_pkg::INDEX_W'($urandom_range(0, 15));
        else
            item.slot_index = pcst_pkg::INDEX_W'($urandom_range(0, SLOTS - 1));
        return item;
    endfunction

    initial
    begin
        rsp.ready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            if (slot_replies.size() == 0)
            begin
                $error("result with nothing expected: slot %0d peer_node %0d status %0d",
                       rsp.payload.slot, rsp.payload.peer_node, rsp.payload.status);
                errors++;
            end
            else
            begin
                if (rsp.payload.slot !== slot_replies[0].slot)
                begin
                    $error("slot: expected %0d, got %0d",
                           slot_replies[0].slot, rsp.payload.slot);
                    errors++;
                end
                if (rsp.payload.peer_node !== slot_replies[0].peer_node)
                begin
                    $error("peer_node: expected %0d, got %0d",
                           slot_replies[0].peer_node, rsp.payload.peer_node);
                    errors++;
                end
                if (rsp.payload.status !== slot_replies[0].status)
                begin
                    $error("status: expected %0d, got %0d",
                           slot_replies[0].status, rsp.payload.status);
                    errors++;
                end
                void'(slot_replies.pop_front());
            end
        end
    end

    initial
    begin
        req.valid   <= 1'b0;
        req.payload <= '0;
        for (int i = 0; i < SLOTS; i++)
            peer_slots[i] = pcst_pkg::NODE_FREE;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < PLAN_ROWS; r++)
            issue(opening_plan[r].item, opening_plan[r].typed, opening_plan[r].want);

        drain_replies();
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
                drain_replies();
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            issue(random_item(), 1'b0, '0);
        end

        drain_replies();
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
